>>> rtl/i2p_pkg.sv
// ---------------------------------------------------------------------------
// i2p_pkg: shared definitions for the infix to postfix converter
// Stack sizing, character codes, precedence functions and the command and
// status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2p_pkg;

  // Operator stack sizing. Entry 0 is the bottom marker; it is never written and its read data is never used.
  localparam int STACK_DEPTH = 32;
  localparam int TOP_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [TOP_W-1:0] TOP_MAX = TOP_W'(STACK_DEPTH - 1);

  // Character codes that the precedence functions single out.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_TERM   = 8'h00;

  // Precedences are carried biased by one so they stay unsigned.
  localparam int PREC_W = 4;
  typedef logic [PREC_W-1:0] prec_t;

  // Input precedence G plus one.
  function automatic prec_t prec_in(input logic [7:0] c);
    prec_t p;
    case (c)
      CH_PLUS, CH_MINUS:  p = prec_t'(2);
      CH_STAR, CH_SLASH:  p = prec_t'(4);
      CH_CARET, CH_DOLLAR: p = prec_t'(7);
      CH_LPAREN:          p = prec_t'(10);
      CH_RPAREN:          p = prec_t'(1);
      default:            p = prec_t'(8);
    endcase
    return p;
  endfunction

  // Stack-top precedence F plus one.
  function automatic prec_t prec_stack(input logic [7:0] c);
    prec_t p;
    case (c)
      CH_PLUS, CH_MINUS:  p = prec_t'(3);
      CH_STAR, CH_SLASH:  p = prec_t'(5);
      CH_CARET, CH_DOLLAR: p = prec_t'(6);
      CH_LPAREN:          p = prec_t'(1);
      CH_HASH:            p = prec_t'(0);
      default:            p = prec_t'(9);
    endcase
    return p;
  endfunction

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EVAL_WAIT,
    S_TAIL,
    S_FLUSH,
    S_FLUSH_WAIT,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input word
    logic pop;         // drop the top entry
    logic push;        // push the held symbol, or flag overflow when full
    logic emit_top;    // emit the top entry
    logic emit_term;   // emit the expression terminator
    logic finish;      // release the held result as the last of its run
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic f_gt_g;      // stack-top precedence above input precedence
    logic f_eq_g;      // precedences equal (matched parenthesis)
    logic top_zero;    // only the bottom marker remains
    logic can_emit;    // a new result can be taken this cycle
    logic can_finish;  // the held result can go out this cycle
    logic held_valid;  // a result is held back
    logic end_flag;    // the current word ends the expression
  } dp_status_t;

endpackage

>>> rtl/i2p_ram.sv
// ---------------------------------------------------------------------------
// i2p_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/i2p_ctrl.sv
// ---------------------------------------------------------------------------
// i2p_ctrl: sequencing controller
// Steps one word through the pop, match, push and flush phases and issues
// datapath commands. Every stack change is followed by a wait state that lets
// the registered stack read catch up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2p_ctrl import i2p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.f_gt_g) begin
          if (status.can_emit) begin
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
            state_next   = S_EVAL_WAIT;
          end
        end else if (status.f_eq_g) begin
          cmd.pop    = 1'b1;
          state_next = S_TAIL;
        end else begin
          cmd.push   = 1'b1;
          state_next = S_TAIL;
        end
      end
      S_EVAL_WAIT: begin
        state_next = S_EVAL;
      end
      S_TAIL: begin
        state_next = status.end_flag ? S_FLUSH : S_FINISH;
      end
      S_FLUSH: begin
        if (status.can_emit) begin
          if (status.top_zero) begin
            cmd.emit_term = 1'b1;
            state_next    = S_FINISH;
          end else begin
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
            state_next   = S_FLUSH_WAIT;
          end
        end
      end
      S_FLUSH_WAIT: begin
        state_next = S_FLUSH;
      end
      S_FINISH: begin
        if (!status.held_valid) begin
          state_next = S_IDLE;
        end else if (status.can_finish) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/i2p_datapath.sv
// ---------------------------------------------------------------------------
// i2p_datapath: operator stack and result registers
// Holds the stack pointer, the stack RAM, the overflow flag, one held-back
// result (so the last of a run can be marked) and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2p_datapath import i2p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_symbol,
  input  logic       in_end,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_done,
  output logic       out_ovf
);

  logic [TOP_W-1:0] stack_top;
  logic             overflow_seen;
  logic [7:0]       sym_reg;
  logic             end_reg;
  logic [7:0]       held_char;
  logic             held_done;
  logic             held_ovf;
  logic             held_valid;
  logic [7:0]       top_char;
  logic             push_ok;
  logic             out_free;
  logic             emit;
  logic             out_load;
  prec_t            f_prec;
  prec_t            g_prec;

  // Stack storage; the read port always follows the stack pointer.
  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push && push_ok),
    .wr_addr (stack_top + TOP_W'(1)),
    .wr_data (sym_reg),
    .rd_addr (stack_top),
    .rd_data (top_char)
  );

  // Precedence compare; the bottom marker reads as the lowest precedence.
  always_comb begin
    f_prec   = (stack_top == '0) ? prec_t'(0) : prec_stack(top_char);
    g_prec   = prec_in(sym_reg);
    push_ok  = (stack_top != TOP_MAX);
    out_free = !out_valid || out_ready;
    emit     = cmd.emit_top || cmd.emit_term;
    out_load = (emit && held_valid) || cmd.finish;
  end

  assign status.f_gt_g     = (f_prec > g_prec);
  assign status.f_eq_g     = (f_prec == g_prec);
  assign status.top_zero   = (stack_top == '0);
  assign status.can_emit   = !held_valid || out_free;
  assign status.can_finish = out_free;
  assign status.held_valid = held_valid;
  assign status.end_flag   = end_reg;

  // Stack pointer and sticky overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top     <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.pop) begin
      stack_top <= stack_top - TOP_W'(1);
    end else if (cmd.push) begin
      if (push_ok) begin
        stack_top <= stack_top + TOP_W'(1);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // Input word capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_reg <= in_symbol;
      end_reg <= in_end;
    end
  end

  // Held result: a new result waits here until the next one or the finish.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (emit) begin
      held_valid <= 1'b1;
    end else if (cmd.finish) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      held_char <= cmd.emit_term ? CH_TERM : top_char;
      held_done <= cmd.emit_term;
      held_ovf  <= overflow_seen;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char <= held_char;
      out_last <= cmd.finish;
      out_done <= held_done;
      out_ovf  <= held_ovf;
    end
  end

endmodule

>>> rtl/infix_to_postfix_converter_core.sv
// Sequence: a word with nothing to pop passes the accept, compare, settle and
//   finish states; each popped or flushed entry adds a wait state for the registered
//   stack read, and the terminator of an end word is emitted from the flush state.
// Flow: one word at a time; a new word is accepted only in the idle state, and output
//   stalls hold the converter. Results leave through one output register.
// Reset: synchronous; empties the stack, clears the overflow flag, drops pending words.
// ---------------------------------------------------------------------------
// infix_to_postfix_converter_core: infix to postfix stream converter
// Rewrites infix characters to postfix with an operator stack and
// precedence functions, flushing on the last word of an expression.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_to_postfix_converter_core import i2p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [0] expr_done, [1] overflow
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing controller.
  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stack and result datapath.
  i2p_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_symbol (s_axis_tdata),
    .in_end    (s_axis_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_done  (m_axis_tuser[0]),
    .out_ovf   (m_axis_tuser[1])
  );

endmodule

>>> rtl/i2p_checker.sv
// ---------------------------------------------------------------------------
// i2p_checker: port-level checks for the converter
// Watches the output stream for terminator, stall and overflow rules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2p_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  logic ovf_seen;

  // Remembers that a word with the overflow flag has gone out.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_seen <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[1]) begin
      ovf_seen <= 1'b1;
    end
  end

  // A terminator is always the last word of its run and carries zero.
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
    else $error("terminator word not last or not zero");

  // Once reported, the overflow flag stays set until reset.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ovf_seen) |-> m_axis_tuser[1])
    else $error("overflow flag dropped after being reported");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("stalled output word changed");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (.*);
